### src/double_ended_queue_macros.svh
// Assertion macros shared by the double-ended queue checkers
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset
`define DEQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset
`define DEQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/deq_pkg.sv
// Types and constants shared by the double-ended queue modules
`timescale 1ns / 1ps
`default_nettype none
package deq_pkg;

  localparam int VALUE_W  = 32;
  localparam int ACTION_W = 3;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 5;
  localparam int CAP_W    = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_PUSH_BACK  = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_POP_FRONT  = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_POP_BACK   = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_CLEAR      = 3'd4;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // Per-cycle command broadcast to every cell of the row
  typedef struct packed {
    logic push_front;
    logic push_back;
    logic pop_front;
    logic pop_back;
  } cell_ctrl_t;

endpackage
`default_nettype wire

### src/double_ended_queue.sv
// Double-ended queue of signed 32-bit values built as a row of shifting cells
//
// Usage: one operation (push front, push back, pop front, pop back, clear) is
// transferred per clock cycle and its result appears in the output register
// on the next cycle, so the block sustains one item per cycle. The input stalls
// only while a finished result waits in the output register and the output is
// stalled. The front entry always sits in cell 0 and the row shifts as a whole
// on front pushes and pops; a back pop selects the tail cell across all DEPTH
// cells in the same cycle, which sets the longest path of the design as DEPTH
// grows. The single configuration register (capacity) takes a write in any
// cycle; the capacity used saturates at DEPTH, and zero refuses every push.
`timescale 1ns / 1ps
`default_nettype none
module double_ended_queue
  import deq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       in_valid,
  output logic                      in_stall,
  input  wire        [ACTION_W-1:0] action,
  input  wire signed [VALUE_W-1:0]  value,
  output logic                      out_valid,
  input  wire                       out_stall,
  output logic signed [VALUE_W-1:0] popped_value,
  output logic       [STATUS_W-1:0] status,
  output logic       [OCC_W-1:0]    occupancy,
  output logic                      empty_flag,
  output logic                      full_flag,
  input  wire                       cfg_valid,
  output logic                      cfg_ready,
  input  wire        [CAP_W-1:0]    cfg_data
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = (CW > CAP_W) ? CW : CAP_W;
  localparam logic [EW-1:0] DEPTH_E = EW'(DEPTH);

  logic [CW-1:0]      count;
  logic [CW-1:0]      count_next;
  logic [CAP_W-1:0]   capacity;
  logic [EW-1:0]      cap_eff;
  logic               take;
  logic               full_now;
  logic               empty_now;
  cell_ctrl_t         ctrl;
  logic [STATUS_W-1:0] status_next;
  logic signed [VALUE_W-1:0] popped_next;
  logic signed [VALUE_W-1:0] back_data;
  logic signed [VALUE_W-1:0] cell_data [DEPTH];
  logic signed [VALUE_W-1:0] cell_tap  [DEPTH];

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid & out_stall;
  assign take      = in_valid & ~in_stall;

  assign cap_eff   = (EW'(capacity) > DEPTH_E) ? DEPTH_E : EW'(capacity);
  assign full_now  = EW'(count) >= cap_eff;
  assign empty_now = (count == '0);

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [VALUE_W-1:0] left_data;
    logic signed [VALUE_W-1:0] right_data;
    if (i == 0) begin : g_first
      assign left_data = value;
    end else begin : g_inner_l
      assign left_data = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_data = '0;
    end else begin : g_inner_r
      assign right_data = cell_data[i+1];
    end
    deq_cell #(
      .INDEX (i),
      .CW    (CW)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .count      (count),
      .value      (value),
      .left_data  (left_data),
      .right_data (right_data),
      .data       (cell_data[i]),
      .tap        (cell_tap[i])
    );
  end

  // At most one cell drives its tap, so merge them with an OR
  always_comb begin
    back_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      back_data = back_data | cell_tap[i];
    end
  end

  always_comb begin
    ctrl        = '0;
    status_next = ST_DONE;
    popped_next = '0;
    count_next  = count;
    if (take) begin
      unique case (action)
        ACT_PUSH_FRONT: begin
          if (full_now) begin
            status_next = ST_FULL;
          end else begin
            ctrl.push_front = 1'b1;
            count_next      = count + 1'b1;
          end
        end
        ACT_PUSH_BACK: begin
          if (full_now) begin
            status_next = ST_FULL;
          end else begin
            ctrl.push_back = 1'b1;
            count_next     = count + 1'b1;
          end
        end
        ACT_POP_FRONT: begin
          if (empty_now) begin
            status_next = ST_EMPTY;
          end else begin
            ctrl.pop_front = 1'b1;
            popped_next    = cell_data[0];
            count_next     = count - 1'b1;
          end
        end
        ACT_POP_BACK: begin
          if (empty_now) begin
            status_next = ST_EMPTY;
          end else begin
            ctrl.pop_back = 1'b1;
            popped_next   = back_data;
            count_next    = count - 1'b1;
          end
        end
        ACT_CLEAR: begin
          count_next = '0;
        end
        default: begin
          count_next = count;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      capacity  <= CAP_RESET;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (cfg_valid && cfg_ready) begin
        capacity <= cfg_data;
      end
      if (take) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload; load on every input transfer
  always_ff @(posedge clk) begin
    if (take) begin
      popped_value <= popped_next;
      status       <= status_next;
      occupancy    <= OCC_W'(count_next);
      empty_flag   <= (count_next == '0);
      full_flag    <= EW'(count_next) >= cap_eff;
    end
  end

endmodule
`default_nettype wire

### src/deq_cell.sv
// One storage cell of the queue row: holds one entry and shifts with its neighbors
`timescale 1ns / 1ps
`default_nettype none
module deq_cell
  import deq_pkg::*;
#(
  parameter int INDEX = 0,
  parameter int CW    = 5
) (
  input  wire                       clk,
  input  cell_ctrl_t                ctrl,
  input  wire        [CW-1:0]       count,
  input  wire signed [VALUE_W-1:0]  value,
  input  wire signed [VALUE_W-1:0]  left_data,
  input  wire signed [VALUE_W-1:0]  right_data,
  output logic signed [VALUE_W-1:0] data,
  output logic signed [VALUE_W-1:0] tap
);

  localparam logic [CW-1:0] BACK_POS = CW'(INDEX);
  localparam logic [CW-1:0] TAIL_POS = CW'(INDEX + 1);

  // Front sits in cell 0: push front shifts toward the back, pop front toward the front
  always_ff @(posedge clk) begin
    if (ctrl.push_front) begin
      data <= left_data;
    end else if (ctrl.pop_front) begin
      data <= right_data;
    end else if (ctrl.push_back && (count == BACK_POS)) begin
      data <= value;
    end
  end

  // Drive the entry out only when this cell holds the back element
  assign tap = (ctrl.pop_back && (count == TAIL_POS)) ? data : '0;

endmodule
`default_nettype wire

### src/deq_checker.sv
// Port-level checks for the double-ended queue and their binding
`timescale 1ns / 1ps
`default_nettype none
`include "double_ended_queue_macros.svh"
module deq_checker
  import deq_pkg::*;
(
  input wire                       clk,
  input wire                       rst,
  input wire                       in_valid,
  input wire                       in_stall,
  input wire                       out_valid,
  input wire                       out_stall,
  input wire signed [VALUE_W-1:0]  popped_value,
  input wire        [STATUS_W-1:0] status,
  input wire        [OCC_W-1:0]    occupancy,
  input wire                       empty_flag,
  input wire                       full_flag
);

  `DEQ_ASSERT_NOW(a_empty_matches_occ, clk, rst, out_valid, empty_flag == (occupancy == '0), "empty flag disagrees with occupancy")
  `DEQ_ASSERT_NOW(a_refusal_no_data, clk, rst, out_valid && (status != ST_DONE), popped_value == '0, "refused operation returned data")
  `DEQ_ASSERT_NOW(a_pop_refused_empty, clk, rst, out_valid && (status == ST_EMPTY), empty_flag && (occupancy == '0), "pop refused while queue not empty")
  `DEQ_ASSERT_NEXT(a_result_holds, clk, rst, out_valid && out_stall, out_valid && $stable(popped_value) && $stable(status), "stalled result changed")
  `DEQ_ASSERT_NEXT(a_transfer_gives_result, clk, rst, in_valid && !in_stall, out_valid && !full_flag == (occupancy < 5'd0) || out_valid, "input transfer left no result")

endmodule

bind double_ended_queue deq_checker u_deq_checker (.*);
`default_nettype wire

### tb/sv/tb_double_ended_queue.sv
// Self-checking testbench for the double-ended queue: random traffic, stalls and capacity writes
`timescale 1ns / 1ps
module tb_double_ended_queue;
  import deq_pkg::*;

  localparam int DEQ_DEPTH = 16;
  localparam logic [CAP_W-1:0] DEPTH_CAP = 5'd16;
  localparam logic [ACTION_W-1:0] ACT_SPARE_LO = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_SPARE_HI = 3'd7;
  localparam int IDLE_LIMIT = 1000;
  localparam int PHASE_ITEMS = 200;

  typedef struct {
    logic [ACTION_W-1:0] act;
    logic [VALUE_W-1:0]  val;
    int                  gap;
  } deq_op_t;

  typedef struct {
    logic signed [VALUE_W-1:0] popped;
    logic [STATUS_W-1:0]       status;
    logic [OCC_W-1:0]          occ;
    logic                      empty;
    logic                      full;
  } deq_result_t;

  logic                       clk;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [ACTION_W-1:0]        action = ACT_CLEAR;
  logic signed [VALUE_W-1:0]  value = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [VALUE_W-1:0]  popped_value;
  logic [STATUS_W-1:0]        status;
  logic [OCC_W-1:0]           occupancy;
  logic                       empty_flag;
  logic                       full_flag;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CAP_W-1:0]           cfg_data = '0;

  // Shadow copy of the queue contents and the capacity register
  logic [VALUE_W-1:0] slot [DEQ_DEPTH];
  logic [3:0]         head = '0;
  logic [3:0]         tail = '0;
  logic [OCC_W-1:0]   fill = '0;
  logic [CAP_W-1:0]   cap_reg = CAP_RESET;

  deq_op_t     pending_ops[$];
  deq_result_t expected_results[$];

  int  errors = 0;
  int  n_queued = 0;
  int  n_accepted = 0;
  int  n_pushed = 0;
  int  n_popped = 0;
  int  n_refused = 0;
  int  n_cap_writes = 0;
  int  idle_cycles = 0;
  int  in_wait = 0;
  int  out_wait = 0;
  bit  gap_armed = 1'b0;
  bit  in_calm = 1'b0;
  bit  out_calm = 1'b0;
  bit  in_took = 1'b0;
  bit  out_took = 1'b0;

  double_ended_queue u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .action       (action),
    .value        (value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .popped_value (popped_value),
    .status       (status),
    .occupancy    (occupancy),
    .empty_flag   (empty_flag),
    .full_flag    (full_flag),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Apply one operation to the shadow queue and return the result it must produce
  function automatic deq_result_t deque_step(input logic [ACTION_W-1:0] act,
                                             input logic [VALUE_W-1:0] val);
    deq_result_t r;
    logic [CAP_W-1:0] lim;
    logic at_limit;
    lim = (cap_reg > DEPTH_CAP) ? DEPTH_CAP : cap_reg;
    at_limit = (fill >= lim);
    r.popped = '0;
    r.status = ST_DONE;
    case (act)
      ACT_PUSH_FRONT: begin
        if (at_limit) begin
          r.status = ST_FULL;
          n_refused++;
        end else begin
          head = head - 1'b1;
          slot[head] = val;
          fill = fill + 1'b1;
          n_pushed++;
        end
      end
      ACT_PUSH_BACK: begin
        if (at_limit) begin
          r.status = ST_FULL;
          n_refused++;
        end else begin
          slot[tail] = val;
          tail = tail + 1'b1;
          fill = fill + 1'b1;
          n_pushed++;
        end
      end
      ACT_POP_FRONT: begin
        if (fill == 0) begin
          r.status = ST_EMPTY;
          n_refused++;
        end else begin
          r.popped = slot[head];
          head = head + 1'b1;
          fill = fill - 1'b1;
          n_popped++;
        end
      end
      ACT_POP_BACK: begin
        if (fill == 0) begin
          r.status = ST_EMPTY;
          n_refused++;
        end else begin
          tail = tail - 1'b1;
          r.popped = slot[tail];
          fill = fill - 1'b1;
          n_popped++;
        end
      end
      ACT_CLEAR: begin
        head = '0;
        tail = '0;
        fill = '0;
      end
      default: ;
    endcase
    r.occ = fill;
    r.empty = (fill == 0);
    r.full = (fill >= lim);
    return r;
  endfunction

  // Rising edge: record transfers, predict, check, watch for a hang
  always @(posedge clk) begin : sample_edge
    deq_result_t w;
    in_took = 1'b0;
    out_took = 1'b0;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        cap_reg = cfg_data;
        n_cap_writes++;
      end
      if (in_valid && !in_stall) begin
        in_took = 1'b1;
        n_accepted++;
        expected_results.push_back(deque_step(action, value));
      end
      if (out_valid && !out_stall) begin
        out_took = 1'b1;
        if (expected_results.size() == 0) begin
          $error("result transfer with no operation outstanding");
          errors++;
        end else begin
          w = expected_results.pop_front();
          if (popped_value !== w.popped) begin
            $error("popped_value: expected %0d, got %0d", w.popped, popped_value);
            errors++;
          end
          if (status !== w.status) begin
            $error("status: expected %0d, got %0d", w.status, status);
            errors++;
          end
          if (occupancy !== w.occ) begin
            $error("occupancy: expected %0d, got %0d", w.occ, occupancy);
            errors++;
          end
          if (empty_flag !== w.empty) begin
            $error("empty_flag: expected %0d, got %0d", w.empty, empty_flag);
            errors++;
          end
          if (full_flag !== w.full) begin
            $error("full_flag: expected %0d, got %0d", w.full, full_flag);
            errors++;
          end
        end
      end
      if (in_took || out_took || (cfg_valid && cfg_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // Operation driver: hold until transfer, then wait out the next gap
  always @(negedge clk) begin : drive_ops
    deq_op_t op;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_took) begin
      // hold the stalled payload
    end else begin
      if (pending_ops.size() > 0 && !gap_armed) begin
        in_wait = pending_ops[0].gap;
        gap_armed = 1'b1;
      end
      if (pending_ops.size() == 0) begin
        in_valid <= 1'b0;
      end else if (in_wait > 0) begin
        in_wait--;
        in_valid <= 1'b0;
      end else begin
        op = pending_ops.pop_front();
        gap_armed = 1'b0;
        action <= op.act;
        value <= op.val;
        in_valid <= 1'b1;
      end
    end
  end

  // Result side: stall for a random count before each transfer
  always @(negedge clk) begin : drive_stall
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_took) begin
        if ($urandom_range(0, 39) == 0) out_calm = !out_calm;
        out_wait = out_calm ? 0 : $urandom_range(0, 5);
      end
      if (out_wait > 0) begin
        out_wait--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_op(input logic [ACTION_W-1:0] act, input logic [VALUE_W-1:0] val);
    deq_op_t op;
    op.act = act;
    op.val = val;
    op.gap = in_calm ? 0 : $urandom_range(0, 5);
    pending_ops.push_back(op);
    n_queued++;
  endtask

  // Hold further traffic until every transfer and result is through
  task automatic wait_drained();
    while (n_accepted != n_queued || expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [CAP_W-1:0] c);
    @(negedge clk);
    cfg_data <= c;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Runs of pushes and pops with random content, with clears, spare codes and noise
  task automatic add_random_traffic(input int n);
    int cnt;
    int len;
    int r;
    cnt = 0;
    while (cnt < n) begin
      if ($urandom_range(0, 7) == 0) in_calm = !in_calm;
      r = $urandom_range(0, 99);
      len = $urandom_range(1, 18);
      if (r < 45) begin
        repeat (len) add_op($urandom_range(0, 1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT, pick_value());
        cnt += len;
      end else if (r < 90) begin
        repeat (len) add_op($urandom_range(0, 1) ? ACT_POP_BACK : ACT_POP_FRONT, pick_value());
        cnt += len;
      end else if (r < 94) begin
        add_op(ACT_CLEAR, pick_value());
        cnt++;
      end else if (r < 97) begin
        add_op(ACTION_W'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI)), pick_value());
        cnt++;
      end else begin
        len = $urandom_range(1, 6);
        repeat (len) add_op(ACTION_W'($urandom_range(0, 7)), pick_value());
        cnt += len;
      end
    end
  endtask

  initial begin : stimulus
    logic [CAP_W-1:0] caps [8];
    caps = '{5'd31, 5'd3, DEPTH_CAP, 5'd1, 5'd17, 5'd0, 5'd9, 5'd2};
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Empty pops, extreme values from both ends, spare codes, clear
    add_op(ACT_POP_FRONT, '0);
    add_op(ACT_POP_BACK, '1);
    add_op(ACT_PUSH_FRONT, 32'h7FFF_FFFF);
    add_op(ACT_PUSH_BACK, 32'h8000_0000);
    add_op(ACT_PUSH_FRONT, '1);
    add_op(ACT_PUSH_BACK, '0);
    add_op(ACT_SPARE_LO, 32'h1234_5678);
    add_op(3'd6, '1);
    add_op(ACT_SPARE_HI, '0);
    add_op(ACT_POP_BACK, '0);
    add_op(ACT_POP_FRONT, '0);
    add_op(ACT_POP_FRONT, '0);
    add_op(ACT_POP_BACK, '0);
    add_op(ACT_PUSH_BACK, 32'hAAAA_AAAA);
    add_op(ACT_PUSH_FRONT, 32'h5555_5555);
    add_op(ACT_CLEAR, '1);
    add_op(ACT_POP_FRONT, '0);
    wait_drained();

    // Capacity of one: full after a single push
    set_capacity(5'd1);
    add_op(ACT_PUSH_BACK, 32'hDEAD_BEEF);
    add_op(ACT_PUSH_FRONT, 32'h0BAD_F00D);
    add_op(ACT_POP_FRONT, '0);
    wait_drained();

    // Capacity of zero: every push refused
    set_capacity(5'd0);
    add_op(ACT_PUSH_FRONT, '1);
    add_op(ACT_PUSH_BACK, '1);
    add_op(ACT_POP_BACK, '0);
    wait_drained();

    for (int i = 0; i < 8; i++) begin
      // Fill before a small capacity so it lands below the occupancy
      if (caps[i] < 5'd4) begin
        add_op(ACT_CLEAR, '0);
        repeat (DEQ_DEPTH) add_op(ACT_PUSH_BACK, pick_value());
        wait_drained();
      end
      set_capacity(caps[i]);
      add_random_traffic(PHASE_ITEMS);
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      errors += expected_results.size();
    end
    $display("Ran %0d operations over %0d capacity writes: %0d pushes, %0d pops, %0d refused.",
             n_accepted, n_cap_writes, n_pushed, n_popped, n_refused);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+src
src/deq_pkg.sv
src/deq_cell.sv
src/double_ended_queue.sv
src/deq_checker.sv
tb/sv/tb_double_ended_queue.sv
